// ----- sv/pbhc_pkg.sv -----
package pbhc_pkg;

  localparam int ERROR_FRAC_BITS_DEF = 4;

  localparam int CUT_W  = 13;
  localparam int OFF_W  = 8;
  localparam int CODE_W = 12;
  localparam int PID_W  = 16;
  localparam int INT_W  = 32;

  localparam int GP_W = 16;
  localparam int GI_W = 16;
  localparam int GD_W = 20;
  localparam int SP_W = 13;
  localparam int DB_W = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 3'd4;

  localparam logic [GP_W-1:0]        GAIN_P_RST   = 16'd2048;
  localparam logic [GI_W-1:0]        GAIN_I_RST   = 16'd51;
  localparam logic [GD_W-1:0]        GAIN_D_RST   = 20'd15872;
  localparam logic signed [SP_W-1:0] SETPOINT_RST = 13'sd336;
  localparam logic [DB_W-1:0]        DEADBAND_RST = 8'd5;

  // (whole + 150) * 4096 / 300 == ((whole + 150) * MAP_RECIP) >> MAP_SHIFT for 1..299
  localparam int                  MAP_N_W    = 9;
  localparam logic [PID_W-1:0]    MAP_OFFSET = 16'd150;
  localparam logic [GD_W-1:0]     MAP_RECIP  = 20'd894785;
  localparam int                  MAP_SHIFT  = 16;
  localparam logic [CODE_W-1:0]   CODE_MAX   = 12'd4095;
  localparam logic [CODE_W-1:0]   CODE_MIN   = 12'd0;

  typedef logic [1:0] mul_sel_t;

  localparam mul_sel_t SEL_P   = 2'd0;
  localparam mul_sel_t SEL_I   = 2'd1;
  localparam mul_sel_t SEL_D   = 2'd2;
  localparam mul_sel_t SEL_MAP = 2'd3;

  typedef struct packed {
    logic     capture;
    logic     diff_en;
    logic     last_en;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_load;
    logic     int_upd;
    logic     acc_sum;
    logic     whole_en;
    logic     map_en;
    logic     out_load;
  } dp_cmd_t;

endpackage

// ----- sv/pbhc_if.sv -----
interface pbhc_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [pbhc_pkg::CUT_W-1:0] cut_delta;
  logic signed [pbhc_pkg::OFF_W-1:0] blade_offset;

  modport source (output valid, cut_delta, blade_offset, input ready);
  modport sink   (input valid, cut_delta, blade_offset, output ready);
endinterface

interface pbhc_out_if;
  logic                              valid;
  logic                              ready;
  logic [pbhc_pkg::CODE_W-1:0]       dac_code;
  logic                              dac_write;
  logic signed [pbhc_pkg::PID_W-1:0] pid_sum;

  modport source (output valid, dac_code, dac_write, pid_sum, input ready);
  modport sink   (input valid, dac_code, dac_write, pid_sum, output ready);
endinterface

// ----- sv/pbhc_ctrl.sv -----
module pbhc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output pbhc_pkg::dp_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL_P = 3'd1;
  localparam logic [2:0] S_MUL_I = 3'd2;
  localparam logic [2:0] S_MUL_D = 3'd3;
  localparam logic [2:0] S_SUM   = 3'd4;
  localparam logic [2:0] S_WHOLE = 3'd5;
  localparam logic [2:0] S_MAP   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    cmd.mul_sel = pbhc_pkg::SEL_P;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_MUL_P;
        end
      end
      S_MUL_P: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pbhc_pkg::SEL_P;
        cmd.diff_en = 1'b1;
        state_next  = S_MUL_I;
      end
      S_MUL_I: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = pbhc_pkg::SEL_I;
        cmd.acc_load = 1'b1;
        cmd.last_en  = 1'b1;
        state_next   = S_MUL_D;
      end
      S_MUL_D: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pbhc_pkg::SEL_D;
        cmd.int_upd = 1'b1;
        state_next  = S_SUM;
      end
      S_SUM: begin
        cmd.acc_sum = 1'b1;
        state_next  = S_WHOLE;
      end
      S_WHOLE: begin
        cmd.whole_en = 1'b1;
        state_next   = S_MAP;
      end
      S_MAP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pbhc_pkg::SEL_MAP;
        cmd.map_en  = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_MUL_P)
    else $error("accepted transfer did not start the product sequence");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken while a tick is in progress");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !out_valid || out_ready)
    else $error("pending result overwritten");

endmodule

// ----- sv/pbhc_datapath.sv -----
module pbhc_datapath #(
  parameter int ERROR_FRAC_BITS = pbhc_pkg::ERROR_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  pbhc_pkg::dp_cmd_t                     cmd,
  input  logic                                  cfg_we,
  input  logic [pbhc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pbhc_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic signed [pbhc_pkg::CUT_W-1:0]     cut_delta,
  input  logic signed [pbhc_pkg::OFF_W-1:0]     blade_offset,
  output logic [pbhc_pkg::CODE_W-1:0]           dac_code,
  output logic                                  dac_write,
  output logic signed [pbhc_pkg::PID_W-1:0]     pid_sum
);

  localparam int F      = ERROR_FRAC_BITS;
  localparam int OFFS_W = pbhc_pkg::OFF_W + F;
  localparam int ERR_W  = ((OFFS_W > pbhc_pkg::CUT_W) ? OFFS_W : pbhc_pkg::CUT_W) + 2;
  localparam int A_W    = ERR_W + 1;
  localparam int B_W    = pbhc_pkg::GD_W;
  localparam int PROD_W = A_W + B_W + 1;
  localparam int ISUM_W = PROD_W + 1;
  localparam int ACC_W  = PROD_W + 2;
  localparam int S      = 8 + F;
  localparam int TH_W   = ((OFFS_W > pbhc_pkg::CUT_W) ? OFFS_W : pbhc_pkg::CUT_W) + 1;

  localparam logic signed [ERR_W-1:0]  WIN    = ERR_W'(3 << F);
  localparam logic signed [ISUM_W-1:0] I_MAX  = ISUM_W'(2147483647);
  localparam logic signed [ISUM_W-1:0] I_MIN  = -I_MAX - 1;
  localparam logic signed [ACC_W-1:0]  W_MAX  = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0]  W_MIN  = -W_MAX - 1;
  localparam logic signed [ACC_W-1:0]  BIAS   = ACC_W'((1 << S) - 1);

  logic [pbhc_pkg::GP_W-1:0]        gain_p;
  logic [pbhc_pkg::GI_W-1:0]        gain_i;
  logic [pbhc_pkg::GD_W-1:0]        gain_d;
  logic signed [pbhc_pkg::SP_W-1:0] setpoint;
  logic [pbhc_pkg::DB_W-1:0]        deadband;

  logic signed [ERR_W-1:0]          last_error;
  logic signed [pbhc_pkg::INT_W-1:0] integ;

  logic signed [ERR_W-1:0]          err_r;
  logic signed [A_W-1:0]            diff_r;
  logic                             wr_r;
  logic signed [PROD_W-1:0]         prod;
  logic signed [ACC_W-1:0]          acc;
  logic signed [pbhc_pkg::PID_W-1:0] whole_r;
  logic                             map_lo_r;
  logic                             map_hi_r;

  logic signed [ERR_W-1:0]          err_c;
  logic [pbhc_pkg::CUT_W-1:0]       acut;
  logic                             wr_c;
  logic                             in_win;
  logic signed [A_W-1:0]            mul_a;
  logic [B_W-1:0]                   mul_b;
  logic signed [PROD_W-1:0]         prod_next;
  logic signed [ISUM_W-1:0]         isum;
  logic signed [pbhc_pkg::INT_W-1:0] integ_next;
  logic signed [ACC_W-1:0]          biased;
  logic signed [ACC_W-1:0]          shifted;
  logic signed [pbhc_pkg::PID_W-1:0] whole_next;
  logic signed [pbhc_pkg::PID_W:0]  map_n;
  logic [pbhc_pkg::CODE_W-1:0]      code_next;

  assign err_c = ERR_W'(setpoint) + (ERR_W'(blade_offset) <<< F) - ERR_W'(cut_delta);
  assign acut  = cut_delta[pbhc_pkg::CUT_W-1] ? pbhc_pkg::CUT_W'(-cut_delta)
                                               : pbhc_pkg::CUT_W'(cut_delta);
  assign wr_c  = TH_W'(acut) > (TH_W'(deadband) << F);

  assign in_win = (err_r > -WIN) && (err_r < WIN);

  assign map_n = (pbhc_pkg::PID_W + 1)'(whole_r)
               + (pbhc_pkg::PID_W + 1)'(pbhc_pkg::MAP_OFFSET);

  always_comb begin
    unique case (cmd.mul_sel)
      pbhc_pkg::SEL_P: begin
        mul_a = A_W'(err_r);
        mul_b = B_W'(gain_p);
      end
      pbhc_pkg::SEL_I: begin
        mul_a = A_W'(err_r);
        mul_b = B_W'(gain_i);
      end
      pbhc_pkg::SEL_D: begin
        mul_a = diff_r;
        mul_b = gain_d;
      end
      pbhc_pkg::SEL_MAP: begin
        mul_a = A_W'(map_n[pbhc_pkg::MAP_N_W-1:0]);
        mul_b = pbhc_pkg::MAP_RECIP;
      end
    endcase
  end

  assign prod_next = mul_a * signed'({1'b0, mul_b});

  assign isum = ISUM_W'(integ) + ISUM_W'(prod);

  always_comb begin
    if (!in_win) begin
      integ_next = '0;
    end else if (isum > I_MAX) begin
      integ_next = pbhc_pkg::INT_W'(I_MAX);
    end else if (isum < I_MIN) begin
      integ_next = pbhc_pkg::INT_W'(I_MIN);
    end else begin
      integ_next = pbhc_pkg::INT_W'(isum);
    end
  end

  // truncate toward zero
  assign biased  = acc + (acc[ACC_W-1] ? BIAS : '0);
  assign shifted = biased >>> S;

  always_comb begin
    if (shifted > W_MAX) begin
      whole_next = pbhc_pkg::PID_W'(W_MAX);
    end else if (shifted < W_MIN) begin
      whole_next = pbhc_pkg::PID_W'(W_MIN);
    end else begin
      whole_next = pbhc_pkg::PID_W'(shifted);
    end
  end

  always_comb begin
    if (map_hi_r) begin
      code_next = pbhc_pkg::CODE_MAX;
    end else if (map_lo_r) begin
      code_next = pbhc_pkg::CODE_MIN;
    end else begin
      code_next = prod[pbhc_pkg::MAP_SHIFT +: pbhc_pkg::CODE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p     <= pbhc_pkg::GAIN_P_RST;
      gain_i     <= pbhc_pkg::GAIN_I_RST;
      gain_d     <= pbhc_pkg::GAIN_D_RST;
      setpoint   <= pbhc_pkg::SETPOINT_RST;
      deadband   <= pbhc_pkg::DEADBAND_RST;
      last_error <= '0;
      integ      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pbhc_pkg::CFG_GAIN_P:   gain_p   <= cfg_data[pbhc_pkg::GP_W-1:0];
          pbhc_pkg::CFG_GAIN_I:   gain_i   <= cfg_data[pbhc_pkg::GI_W-1:0];
          pbhc_pkg::CFG_GAIN_D:   gain_d   <= cfg_data[pbhc_pkg::GD_W-1:0];
          pbhc_pkg::CFG_SETPOINT: setpoint <= cfg_data[pbhc_pkg::SP_W-1:0];
          pbhc_pkg::CFG_DEADBAND: deadband <= cfg_data[pbhc_pkg::DB_W-1:0];
          default: ;
        endcase
      end
      if (cmd.last_en) begin
        last_error <= err_r;
      end
      if (cmd.int_upd) begin
        integ <= integ_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      err_r <= err_c;
      wr_r  <= wr_c;
    end
    if (cmd.diff_en) begin
      diff_r <= A_W'(err_r) - A_W'(last_error);
    end
    if (cmd.mul_en) begin
      prod <= prod_next;
    end
    if (cmd.acc_load) begin
      acc <= ACC_W'(prod);
    end else if (cmd.acc_sum) begin
      acc <= acc + ACC_W'(prod) + ACC_W'(integ);
    end
    if (cmd.whole_en) begin
      whole_r <= whole_next;
    end
    if (cmd.map_en) begin
      map_lo_r <= map_n[pbhc_pkg::PID_W] || (map_n == '0);
      map_hi_r <= whole_r >= signed'(pbhc_pkg::MAP_OFFSET);
    end
    if (cmd.out_load) begin
      dac_code  <= code_next;
      dac_write <= wr_r;
      pid_sum   <= whole_r;
    end
  end

  a_integ_cleared: assert property (@(posedge clk) disable iff (rst)
    cmd.int_upd && !in_win |=> integ == '0)
    else $error("integral not cleared outside the error window");

endmodule

// ----- sv/pid_blade_height_controller_core.sv -----
// Blade height PID controller. Each transfer on in_ch is one control tick: the
// error is formed from the setpoint, blade offset and cut delta, then one shared
// multiplier forms the proportional, integral and derivative products and the
// reciprocal product of the 0..4095 drive mapping in turn. A tick runs from
// acceptance to the result being loaded into the output register: the error is
// formed on acceptance, then seven steps of the controller pass through the
// shared multiplier, the accumulator and the truncate/saturate stage. The
// result sits in the output register until taken; the next tick is accepted as
// soon as the result is loaded, so a stalled output holds only the following
// tick in its last step. Gains, setpoint and deadband are written on the cfg port
// (index 0..4); writes to other indices are ignored.
module pid_blade_height_controller_core #(
  parameter int ERROR_FRAC_BITS = pbhc_pkg::ERROR_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  pbhc_in_if.sink                         in_ch,
  pbhc_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [pbhc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pbhc_pkg::CFG_DATA_W-1:0] cfg_data
);

  pbhc_pkg::dp_cmd_t cmd;

  pbhc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  pbhc_datapath #(
    .ERROR_FRAC_BITS (ERROR_FRAC_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cut_delta    (in_ch.cut_delta),
    .blade_offset (in_ch.blade_offset),
    .dac_code     (out_ch.dac_code),
    .dac_write    (out_ch.dac_write),
    .pid_sum      (out_ch.pid_sum)
  );

endmodule
